// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the sensor node status table RTL.
// Each macro wraps one concurrent property, clocked and disabled by reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define SNS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SNS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Plain invariant checked at every clock edge.
`define SNS_ASSERT_ALW(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

// File: rtl/sns_pkg.sv
// Shared types and constants for the sensor node status table.
// Used by the interfaces, the register block and the top level.
`default_nettype none

package sns_pkg;

   // Field widths of the word formats.
   localparam int CMD_W      = 2;
   localparam int NODE_W     = 8;
   localparam int TIME_W     = 32;
   localparam int SEQ_IN_W   = 8;
   localparam int FLOAT_W    = 32;
   localparam int SID_W      = 64;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 4;

   // Register port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Defaults of the top-level parameters.
   localparam int MAX_NODES_DEF = 8;
   localparam int SEQ_WIDTH_DEF = 8;

   // Reset values.
   localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 4'd8;
   localparam logic [TIME_W-1:0]  STALE_MS_RST   = 32'd5000;
   localparam logic [TIME_W-1:0]  AIR_MS_RST     = 32'd10000;
   localparam logic [FLOAT_W-1:0] NAN_BITS       = 32'h7FC0_0000;

   // Commands carried by an input word.
   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_IDENT  = 2'd1,
      CMD_PROBE  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_NO_IDENT  = 3'd2,
      ST_NO_SAMPLE = 3'd3,
      ST_STALE     = 3'd4,
      ST_FAULT     = 3'd5
   } status_type;

   // Register indexes (address bits [3:2]).
   typedef enum logic [1:0] {
      REG_NODE_COUNT = 2'd0,
      REG_STALE_MS   = 2'd1,
      REG_AIR_MS     = 2'd2,
      REG_NONE       = 2'd3
   } reg_index_type;

   // Configuration as seen by the table logic.
   typedef struct packed {
      logic [COUNT_W-1:0] node_count;
      logic [TIME_W-1:0]  stale_ms;
      logic [TIME_W-1:0]  air_ms;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/sns_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on sns_pkg for the field widths.
`default_nettype none

interface sns_req_if;
   logic                              valid;
   logic                              ready;
   logic [sns_pkg::CMD_W-1:0]         cmd;
   logic [sns_pkg::NODE_W-1:0]        node_id;
   logic [sns_pkg::TIME_W-1:0]        now_ms;
   logic [sns_pkg::SEQ_IN_W-1:0]      seq_num;
   logic [sns_pkg::FLOAT_W-1:0]       temp_bits;
   logic [sns_pkg::FLOAT_W-1:0]       humidity_bits;
   logic                              sensor_good;
   logic [sns_pkg::SID_W-1:0]         remote_sensor_id;

   modport source (output valid, cmd, node_id, now_ms, seq_num, temp_bits,
                   humidity_bits, sensor_good, remote_sensor_id, input ready);
   modport sink   (input valid, cmd, node_id, now_ms, seq_num, temp_bits,
                   humidity_bits, sensor_good, remote_sensor_id, output ready);
endinterface

interface sns_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              accepted;
   logic [sns_pkg::STATUS_W-1:0]      status;
   logic                              identity_known;
   logic [sns_pkg::SID_W-1:0]         sensor_id_out;
   logic [sns_pkg::TIME_W-1:0]        age_ms;
   logic [sns_pkg::FLOAT_W-1:0]       temp_out;
   logic [sns_pkg::FLOAT_W-1:0]       humidity_out;
   logic                              sensor_ok_out;
   logic [sns_pkg::SEQ_IN_W-1:0]      seq_out;
   logic                              fresh;

   modport source (output valid, accepted, status, identity_known, sensor_id_out, age_ms,
                   temp_out, humidity_out, sensor_ok_out, seq_out, fresh, input ready);
   modport sink   (input valid, accepted, status, identity_known, sensor_id_out, age_ms,
                   temp_out, humidity_out, sensor_ok_out, seq_out, fresh, output ready);
endinterface

`default_nettype wire

// File: rtl/sns_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic                                          rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/sns_csr.sv
// APB-style configuration registers of the sensor node status table.
// Depends on sns_pkg for the register map and reset values.
`default_nettype none

module sns_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [sns_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [sns_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [sns_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output sns_pkg::cfg_type                      cfg
);
   sns_pkg::cfg_type       cfg_ff;
   sns_pkg::cfg_type       cfg_in;
   sns_pkg::reg_index_type reg_sel;
   logic                   wr_strobe;

   assign reg_sel    = sns_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Next register values on a completed write.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_sel)
            sns_pkg::REG_NODE_COUNT: cfg_in.node_count = csr_pwdata[sns_pkg::COUNT_W-1:0];
            sns_pkg::REG_STALE_MS:   cfg_in.stale_ms   = csr_pwdata;
            sns_pkg::REG_AIR_MS:     cfg_in.air_ms     = csr_pwdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count <= sns_pkg::NODE_COUNT_RST;
         cfg_ff.stale_ms   <= sns_pkg::STALE_MS_RST;
         cfg_ff.air_ms     <= sns_pkg::AIR_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back of the addressed register; unmapped addresses read zero.
   always_comb begin
      case (reg_sel)
         sns_pkg::REG_NODE_COUNT: csr_prdata = sns_pkg::CSR_DATA_W'(cfg_ff.node_count);
         sns_pkg::REG_STALE_MS:   csr_prdata = cfg_ff.stale_ms;
         sns_pkg::REG_AIR_MS:     csr_prdata = cfg_ff.air_ms;
         default:                 csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/sensor_node_status_table.sv
// Sensor node status table: an accepted word is held in the input registers while the memories
// are read, and its response word is registered in the output register; a held response delays
// the next write-back. No new word is taken until the held word completes: the memory read is
// followed by the write-back of the same entry.
// Reset is synchronous and clears the received and identity flags; no clearing pass runs,
// and the configuration registers return to their default values.
`default_nettype none
`include "assert_macros.svh"

module sensor_node_status_table #(
   parameter int MAX_NODES = sns_pkg::MAX_NODES_DEF,
   parameter int SEQ_WIDTH = sns_pkg::SEQ_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sns_req_if.sink                               req_chan,
   sns_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [sns_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [sns_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [sns_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   localparam int IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SEQ_W   = (SEQ_WIDTH < sns_pkg::SEQ_IN_W) ? SEQ_WIDTH : sns_pkg::SEQ_IN_W;
   localparam int T_W     = sns_pkg::TIME_W;
   localparam int F_W     = sns_pkg::FLOAT_W;
   // Sample entry layout, low to high: seq change time, sample time, seq, ok, humidity, temp.
   localparam int TC_LSB   = 0;
   localparam int TS_LSB   = TC_LSB + T_W;
   localparam int SEQ_LSB  = TS_LSB + T_W;
   localparam int OK_BIT   = SEQ_LSB + SEQ_W;
   localparam int HUM_LSB  = OK_BIT + 1;
   localparam int TEMP_LSB = HUM_LSB + F_W;
   localparam int SAMP_W   = TEMP_LSB + F_W;
   localparam logic [sns_pkg::NODE_W-1:0] MAX_NODES_B = sns_pkg::NODE_W'(MAX_NODES);

   sns_pkg::cfg_type cfg;

   // Configuration registers.
   sns_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake and node decode at the input.
   logic                       busy_ff;
   logic                       accept;
   logic                       complete;
   logic                       rsp_valid_ff;
   logic [sns_pkg::NODE_W-1:0] cnt_ext;
   logic [sns_pkg::NODE_W-1:0] cnt_eff;
   logic                       node_ok;
   logic [IDX_W-1:0]           req_idx;

   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;
   assign complete       = busy_ff && (!rsp_valid_ff || rsp_chan.ready);

   assign cnt_ext = sns_pkg::NODE_W'(cfg.node_count);
   assign cnt_eff = (cnt_ext > MAX_NODES_B) ? MAX_NODES_B : cnt_ext;
   assign node_ok = (req_chan.node_id != '0) && (req_chan.node_id <= cnt_eff);
   assign req_idx = IDX_W'(req_chan.node_id - sns_pkg::NODE_W'(1));

   // Word held while the memories are read.
   sns_pkg::cmd_type            cmd_ff;
   logic                        node_ok_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [T_W-1:0]              now_ff;
   logic [SEQ_W-1:0]            seq_ff;
   logic [F_W-1:0]              temp_ff;
   logic [F_W-1:0]              hum_ff;
   logic                        good_ff;
   logic [sns_pkg::SID_W-1:0]   rid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (complete) begin
         busy_ff <= 1'b0;
      end
      if (accept) begin
         cmd_ff     <= sns_pkg::cmd_type'(req_chan.cmd);
         node_ok_ff <= node_ok;
         idx_ff     <= req_idx;
         now_ff     <= req_chan.now_ms;
         seq_ff     <= req_chan.seq_num[SEQ_W-1:0];
         temp_ff    <= req_chan.temp_bits;
         hum_ff     <= req_chan.humidity_bits;
         good_ff    <= req_chan.sensor_good;
         rid_ff     <= req_chan.remote_sensor_id;
      end
   end

   // Entry memories: sample record and sensor identity.
   logic                        samp_we;
   logic [SAMP_W-1:0]           samp_wdata;
   logic [SAMP_W-1:0]           samp_rd;
   logic                        id_we;
   logic [sns_pkg::SID_W-1:0]   id_rd;

   sns_ram #(.WIDTH(SAMP_W), .DEPTH(MAX_NODES)) u_samp_ram (
      .clock   (clock),
      .wr_en   (samp_we),
      .wr_addr (idx_ff),
      .wr_data (samp_wdata),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (samp_rd)
   );

   sns_ram #(.WIDTH(sns_pkg::SID_W), .DEPTH(MAX_NODES)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (idx_ff),
      .wr_data (rid_ff),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (id_rd)
   );

   // Per-entry valid flags; an entry without its flag reads as its reset value.
   logic [MAX_NODES-1:0] received_ff;
   logic [MAX_NODES-1:0] ident_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         received_ff <= '0;
         ident_ff    <= '0;
      end else begin
         if (samp_we) begin
            received_ff[idx_ff] <= 1'b1;
         end
         if (id_we) begin
            ident_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Fields of the entry being worked on.
   logic                 rcv;
   logic                 idk;
   logic [F_W-1:0]       temp_rd;
   logic [F_W-1:0]       hum_rd;
   logic                 ok_rd;
   logic [SEQ_W-1:0]     seq_rd;
   logic [T_W-1:0]       ts_rd;
   logic [T_W-1:0]       tc_rd;
   logic [T_W-1:0]       age;
   logic [T_W-1:0]       since_change;
   logic                 advanced;
   logic                 stale;

   assign rcv          = received_ff[idx_ff];
   assign idk          = ident_ff[idx_ff];
   assign temp_rd      = rcv ? samp_rd[TEMP_LSB +: F_W] : sns_pkg::NAN_BITS;
   assign hum_rd       = rcv ? samp_rd[HUM_LSB +: F_W] : sns_pkg::NAN_BITS;
   assign ok_rd        = rcv && samp_rd[OK_BIT];
   assign seq_rd       = rcv ? samp_rd[SEQ_LSB +: SEQ_W] : '0;
   assign ts_rd        = rcv ? samp_rd[TS_LSB +: T_W] : '0;
   assign tc_rd        = rcv ? samp_rd[TC_LSB +: T_W] : '0;
   assign age          = now_ff - ts_rd;
   assign since_change = now_ff - tc_rd;
   assign advanced     = !rcv || (seq_rd != seq_ff);
   assign stale        = !advanced && (since_change > cfg.stale_ms);

   // Response word and write-back for the held command.
   logic                        acc_in;
   sns_pkg::status_type         status_in;
   logic                        idk_in;
   logic [sns_pkg::SID_W-1:0]   sid_in;
   logic [T_W-1:0]              age_in;
   logic [F_W-1:0]              temp_in;
   logic [F_W-1:0]              hum_in;
   logic                        ok_in;
   logic [sns_pkg::SEQ_IN_W-1:0] seq_in;
   logic                        fresh_in;

   always_comb begin
      acc_in     = 1'b0;
      status_in  = sns_pkg::ST_INVALID;
      idk_in     = 1'b0;
      sid_in     = '0;
      age_in     = '0;
      temp_in    = '0;
      hum_in     = '0;
      ok_in      = 1'b0;
      seq_in     = '0;
      fresh_in   = 1'b0;
      samp_we    = 1'b0;
      id_we      = 1'b0;
      samp_wdata = {temp_ff, hum_ff, good_ff, seq_ff, now_ff, advanced ? now_ff : tc_rd};
      if (node_ok_ff) begin
         case (cmd_ff)
            sns_pkg::CMD_SAMPLE: begin
               samp_we = complete;
               if (stale) begin
                  // Refused report: keep the entry, drop its sensor-ok flag.
                  samp_wdata = {temp_rd, hum_rd, 1'b0, seq_rd, ts_rd, tc_rd};
                  status_in  = sns_pkg::ST_STALE;
               end else begin
                  acc_in    = 1'b1;
                  status_in = sns_pkg::ST_OK;
               end
            end
            sns_pkg::CMD_IDENT: begin
               id_we     = complete;
               acc_in    = 1'b1;
               status_in = sns_pkg::ST_OK;
            end
            sns_pkg::CMD_PROBE: begin
               acc_in   = 1'b1;
               idk_in   = idk;
               sid_in   = idk ? id_rd : '0;
               fresh_in = rcv && ok_rd && (age <= cfg.air_ms);
               if (!idk) begin
                  status_in = sns_pkg::ST_NO_IDENT;
               end else if (!rcv) begin
                  status_in = sns_pkg::ST_NO_SAMPLE;
               end else begin
                  age_in  = age;
                  temp_in = temp_rd;
                  hum_in  = hum_rd;
                  ok_in   = ok_rd;
                  seq_in  = sns_pkg::SEQ_IN_W'(seq_rd);
                  if (!ok_rd) begin
                     status_in = sns_pkg::ST_FAULT;
                  end else if (age > cfg.air_ms) begin
                     status_in = sns_pkg::ST_STALE;
                  end else begin
                     status_in = sns_pkg::ST_OK;
                  end
               end
            end
            default: begin
               status_in = sns_pkg::ST_INVALID;
            end
         endcase
      end
   end

   // Output register.
   logic                         acc_ff;
   sns_pkg::status_type          status_ff;
   logic                         idk_ff;
   logic [sns_pkg::SID_W-1:0]    sid_ff;
   logic [T_W-1:0]               age_ff;
   logic [F_W-1:0]               temp_out_ff;
   logic [F_W-1:0]               hum_out_ff;
   logic                         ok_ff;
   logic [sns_pkg::SEQ_IN_W-1:0] seq_out_ff;
   logic                         fresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (complete) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (complete) begin
         acc_ff      <= acc_in;
         status_ff   <= status_in;
         idk_ff      <= idk_in;
         sid_ff      <= sid_in;
         age_ff      <= age_in;
         temp_out_ff <= temp_in;
         hum_out_ff  <= hum_in;
         ok_ff       <= ok_in;
         seq_out_ff  <= seq_in;
         fresh_ff    <= fresh_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accepted       = acc_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.identity_known = idk_ff;
   assign rsp_chan.sensor_id_out  = sid_ff;
   assign rsp_chan.age_ms         = age_ff;
   assign rsp_chan.temp_out       = temp_out_ff;
   assign rsp_chan.humidity_out   = hum_out_ff;
   assign rsp_chan.sensor_ok_out  = ok_ff;
   assign rsp_chan.seq_out        = seq_out_ff;
   assign rsp_chan.fresh          = fresh_ff;

   // Checks on the sequencing of the table logic.
   `SNS_ASSERT_ALW(a_one_store_written, clock, reset, $onehot0({samp_we, id_we}),
                   "both entry memories written in one cycle")
   `SNS_ASSERT_NXT(a_accept_holds, clock, reset, accept, busy_ff,
                   "accepted word not held for the memory read")
   `SNS_ASSERT_NXT(a_complete_shows, clock, reset, complete, rsp_valid_ff && !busy_ff,
                   "completed word did not reach the output register")
   `SNS_ASSERT_IMP(a_refused_status, clock, reset, rsp_valid_ff && !acc_ff,
                   status_ff == sns_pkg::ST_INVALID || status_ff == sns_pkg::ST_STALE,
                   "refused word carries a status other than invalid or stale")

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the sensor node status table.
// Needs sns_pkg and the request and response channel interfaces from the RTL.
`timescale 1ns / 100ps

module tb;
   import sns_pkg::*;

   localparam int TABLE_DEPTH  = MAX_NODES_DEF;
   localparam int NUM_PHASES   = 8;
   localparam int PRESSURE_PH  = 5;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 200000;

   // One request word and one response word, as the channels carry them.
   typedef struct packed {
      cmd_type              cmd;
      logic [NODE_W-1:0]    node_id;
      logic [TIME_W-1:0]    now_ms;
      logic [SEQ_IN_W-1:0]  seq_num;
      logic [FLOAT_W-1:0]   temp_bits;
      logic [FLOAT_W-1:0]   humidity_bits;
      logic                 sensor_good;
      logic [SID_W-1:0]     remote_sensor_id;
   } report_word_type;

   typedef struct packed {
      logic                 accepted;
      status_type           status;
      logic                 identity_known;
      logic [SID_W-1:0]     sensor_id;
      logic [TIME_W-1:0]    age_ms;
      logic [FLOAT_W-1:0]   temp_bits;
      logic [FLOAT_W-1:0]   humidity_bits;
      logic                 sensor_ok;
      logic [SEQ_IN_W-1:0]  seq_num;
      logic                 fresh;
   } status_word_type;

   // Shadow copy of the node table; predicts each response and checks it in order.
   class status_table_scoreboard;
      logic [COUNT_W-1:0]  node_count;
      logic [TIME_W-1:0]   stale_ms;
      logic [TIME_W-1:0]   air_ms;
      logic [FLOAT_W-1:0]  temp_tab [TABLE_DEPTH];
      logic [FLOAT_W-1:0]  hum_tab [TABLE_DEPTH];
      logic                ok_tab [TABLE_DEPTH];
      logic                seen_tab [TABLE_DEPTH];
      logic                ident_tab [TABLE_DEPTH];
      logic [SEQ_IN_W-1:0] seq_tab [TABLE_DEPTH];
      logic [SID_W-1:0]    id_tab [TABLE_DEPTH];
      logic [TIME_W-1:0]   sample_time [TABLE_DEPTH];
      logic [TIME_W-1:0]   seq_change_time [TABLE_DEPTH];
      status_word_type     pending_status_q [$];
      int                  errors;
      int                  requests;
      int                  probes;
      int                  refusals;
      int                  settings;

      function new();
         int i;
         node_count = NODE_COUNT_RST;
         stale_ms   = STALE_MS_RST;
         air_ms     = AIR_MS_RST;
         errors     = 0;
         requests   = 0;
         probes     = 0;
         refusals   = 0;
         settings   = 0;
         for (i = 0; i < TABLE_DEPTH; i++) begin
            temp_tab[i]        = NAN_BITS;
            hum_tab[i]         = NAN_BITS;
            ok_tab[i]          = 1'b0;
            seen_tab[i]        = 1'b0;
            ident_tab[i]       = 1'b0;
            seq_tab[i]         = '0;
            id_tab[i]          = '0;
            sample_time[i]     = '0;
            seq_change_time[i] = '0;
         end
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_NODE_COUNT: node_count = value[COUNT_W-1:0];
            REG_STALE_MS:   stale_ms   = value;
            REG_AIR_MS:     air_ms     = value;
            default: ;
         endcase
         settings++;
      endfunction

      // Counts above the table depth behave as the full table.
      function int unsigned active_nodes();
         return (node_count > TABLE_DEPTH) ? TABLE_DEPTH : node_count;
      endfunction

      function status_word_type predict_status(report_word_type w);
         status_word_type r;
         int unsigned  idx;
         logic [TIME_W-1:0] age;
         logic [TIME_W-1:0] since_change;
         logic advanced;
         r = '0;
         r.status = ST_INVALID;
         if (w.cmd == CMD_PROBE) probes++;
         if (w.cmd == CMD_UNUSED || w.node_id == 0 || w.node_id > active_nodes())
            return r;
         idx = w.node_id - 1;
         r.accepted = 1'b1;
         r.status = ST_OK;
         case (w.cmd)
            CMD_SAMPLE: begin
               advanced = !seen_tab[idx] || (seq_tab[idx] != w.seq_num);
               since_change = w.now_ms - seq_change_time[idx];
               // An unchanged sequence held too long is refused and marks the sensor bad.
               if (!advanced && since_change > stale_ms) begin
                  ok_tab[idx] = 1'b0;
                  r.accepted = 1'b0;
                  r.status = ST_STALE;
                  refusals++;
               end else begin
                  if (advanced) seq_change_time[idx] = w.now_ms;
                  temp_tab[idx]    = w.temp_bits;
                  hum_tab[idx]     = w.humidity_bits;
                  ok_tab[idx]      = w.sensor_good;
                  seen_tab[idx]    = 1'b1;
                  seq_tab[idx]     = w.seq_num;
                  sample_time[idx] = w.now_ms;
               end
            end
            CMD_IDENT: begin
               ident_tab[idx] = 1'b1;
               id_tab[idx]    = w.remote_sensor_id;
            end
            default: begin
               age = w.now_ms - sample_time[idx];
               r.identity_known = ident_tab[idx];
               r.sensor_id = id_tab[idx];
               r.fresh = seen_tab[idx] && ok_tab[idx] && (age <= air_ms);
               if (!ident_tab[idx]) begin
                  r.status = ST_NO_IDENT;
               end else if (!seen_tab[idx]) begin
                  r.status = ST_NO_SAMPLE;
               end else begin
                  r.age_ms        = age;
                  r.temp_bits     = temp_tab[idx];
                  r.humidity_bits = hum_tab[idx];
                  r.sensor_ok     = ok_tab[idx];
                  r.seq_num       = seq_tab[idx];
                  if (!ok_tab[idx])        r.status = ST_FAULT;
                  else if (age > air_ms)   r.status = ST_STALE;
                  else                     r.status = ST_OK;
               end
            end
         endcase
         return r;
      endfunction

      function void note_request(report_word_type w);
         pending_status_q.push_back(predict_status(w));
         requests++;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(status_word_type got);
         status_word_type want;
         if (pending_status_q.size() == 0) begin
            $error("response word arrived with no request outstanding");
            errors++;
            return;
         end
         want = pending_status_q.pop_front();
         compare_field("accepted", want.accepted, got.accepted);
         compare_field("status", want.status, got.status);
         compare_field("identity_known", want.identity_known, got.identity_known);
         compare_field("sensor_id_out", want.sensor_id, got.sensor_id);
         compare_field("age_ms", want.age_ms, got.age_ms);
         compare_field("temp_out", want.temp_bits, got.temp_bits);
         compare_field("humidity_out", want.humidity_bits, got.humidity_bits);
         compare_field("sensor_ok_out", want.sensor_ok, got.sensor_ok);
         compare_field("seq_out", want.seq_num, got.seq_num);
         compare_field("fresh", want.fresh, got.fresh);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sns_req_if req_chan ();
   sns_rsp_if rsp_chan ();

   status_table_scoreboard node_board = new();

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   logic        hold_request  = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;
   logic [TIME_W-1:0] sim_now = '0;

   // Per-phase register settings and handshake pressure.
   logic [COUNT_W-1:0] ph_count [NUM_PHASES] = '{4'd8, 4'd15, 4'd3, 4'd0, 4'd1, 4'd8, 4'd7, 4'd9};
   logic [TIME_W-1:0]  ph_stale [NUM_PHASES] = '{32'd5000, 32'd0, 32'hFFFF_FFFF, 32'd100,
                                                32'd1, 32'd0, 32'd50, 32'd300};
   logic [TIME_W-1:0]  ph_air   [NUM_PHASES] = '{32'd10000, 32'd0, 32'hFFFF_FFFF, 32'd200,
                                                32'hFFFF_FFFE, 32'd0, 32'd75, 32'd300};
   int unsigned ph_send  [NUM_PHASES] = '{0, 62, 0, 20, 20, 0, 62, 0};
   int unsigned ph_stall [NUM_PHASES] = '{0, 0, 62, 20, 20, 0, 0, 62};
   int unsigned ph_items [NUM_PHASES] = '{110, 80, 80, 20, 80, 90, 80, 80};

   sensor_node_status_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d responses still outstanding.",
                  node_board.pending_status_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold when the stimulus asks for it.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Capture each accepted response word and check it against the oldest prediction.
   always @(posedge clock) begin
      status_word_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.accepted       = rsp_chan.accepted;
         got.status         = status_type'(rsp_chan.status);
         got.identity_known = rsp_chan.identity_known;
         got.sensor_id      = rsp_chan.sensor_id_out;
         got.age_ms         = rsp_chan.age_ms;
         got.temp_bits      = rsp_chan.temp_out;
         got.humidity_bits  = rsp_chan.humidity_out;
         got.sensor_ok      = rsp_chan.sensor_ok_out;
         got.seq_num        = rsp_chan.seq_out;
         got.fresh          = rsp_chan.fresh;
         node_board.check_response(got);
      end
   end

   function automatic report_word_type make_report(cmd_type cmd, logic [NODE_W-1:0] node,
                                                   logic [TIME_W-1:0] now,
                                                   logic [SEQ_IN_W-1:0] seq,
                                                   logic [FLOAT_W-1:0] temp,
                                                   logic [FLOAT_W-1:0] hum, logic good,
                                                   logic [SID_W-1:0] rid);
      report_word_type w;
      w.cmd              = cmd;
      w.node_id          = node;
      w.now_ms           = now;
      w.seq_num          = seq;
      w.temp_bits        = temp;
      w.humidity_bits    = hum;
      w.sensor_good      = good;
      w.remote_sensor_id = rid;
      return w;
   endfunction

   // Mostly well-formed traffic on valid nodes, with times aimed at the stale and air limits.
   function automatic report_word_type random_request();
      report_word_type w;
      int unsigned  cnt;
      int unsigned  roll;
      int unsigned  idx;
      int           off;
      roll = $urandom_range(99);
      if (roll < 40)      w.cmd = CMD_SAMPLE;
      else if (roll < 55) w.cmd = CMD_IDENT;
      else if (roll < 95) w.cmd = CMD_PROBE;
      else                w.cmd = CMD_UNUSED;
      cnt = node_board.active_nodes();
      roll = $urandom_range(99);
      if (roll < 85 && cnt > 0) w.node_id = NODE_W'($urandom_range(cnt, 1));
      else if (roll < 95)       w.node_id = NODE_W'(($urandom_range(1) != 0) ? 0 : cnt + 1);
      else                      w.node_id = NODE_W'($urandom_range(255));
      idx = (w.node_id >= 1 && w.node_id <= TABLE_DEPTH) ? w.node_id - 1 : 0;
      off = int'($urandom_range(2)) - 1;
      roll = $urandom_range(99);
      if (roll < 55)
         w.now_ms = sim_now + $urandom_range(600);
      else if (roll < 70)
         w.now_ms = node_board.sample_time[idx] + node_board.air_ms + off;
      else if (roll < 85)
         w.now_ms = node_board.seq_change_time[idx] + node_board.stale_ms + off;
      else
         w.now_ms = $urandom;
      sim_now = w.now_ms;
      roll = $urandom_range(99);
      if (roll < 50)      w.seq_num = node_board.seq_tab[idx];
      else if (roll < 85) w.seq_num = SEQ_IN_W'(node_board.seq_tab[idx] + 1);
      else                w.seq_num = SEQ_IN_W'($urandom_range(255));
      w.temp_bits        = $urandom;
      w.humidity_bits    = $urandom;
      w.sensor_good      = ($urandom_range(9) < 8);
      w.remote_sensor_id = {$urandom, $urandom};
      return w;
   endfunction

   // Offer one request word and hold it until the table takes it.
   task automatic send_request(report_word_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid            <= 1'b1;
      req_chan.cmd              <= w.cmd;
      req_chan.node_id          <= w.node_id;
      req_chan.now_ms           <= w.now_ms;
      req_chan.seq_num          <= w.seq_num;
      req_chan.temp_bits        <= w.temp_bits;
      req_chan.humidity_bits    <= w.humidity_bits;
      req_chan.sensor_good      <= w.sensor_good;
      req_chan.remote_sensor_id <= w.remote_sensor_id;
      do @(posedge clock); while (!req_chan.ready);
      node_board.note_request(w);
   endtask

   // Stop offering and wait until every predicted response has been seen.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (node_board.pending_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase.
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      node_board.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Hand-picked words at the reset settings: node limits, stale refusal, age edges, wrap.
   task automatic run_directed();
      send_request(make_report(CMD_PROBE, 8'd1, 32'd0, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_SAMPLE, 8'd0, 32'd10, 8'd1, '1, '1, 1'b1, '1));
      send_request(make_report(CMD_PROBE, 8'd9, 32'd20, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_IDENT, 8'd255, '1, 8'hFF, '1, '1, 1'b1, '1));
      send_request(make_report(CMD_UNUSED, 8'd1, 32'd30, 8'd5, '1, '1, 1'b1, '1));
      send_request(make_report(CMD_SAMPLE, 8'd1, 32'd1000, 8'd5, '0, '1, 1'b1, '0));
      send_request(make_report(CMD_PROBE, 8'd1, 32'd1000, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_IDENT, 8'd1, 32'd1100, 8'd0, '0, '0, 1'b0, '1));
      // Age exactly at the air timeout, then one past it.
      send_request(make_report(CMD_PROBE, 8'd1, 32'd11000, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_PROBE, 8'd1, 32'd11001, 8'd0, '0, '0, 1'b0, '0));
      // Unchanged sequence right at the stale limit is kept, one past it is refused.
      send_request(make_report(CMD_SAMPLE, 8'd1, 32'd6000, 8'd5, 32'd1, 32'd2, 1'b1, '0));
      send_request(make_report(CMD_SAMPLE, 8'd1, 32'd6001, 8'd5, 32'd3, 32'd4, 1'b1, '0));
      send_request(make_report(CMD_PROBE, 8'd1, 32'd6001, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_SAMPLE, 8'd1, 32'd6002, 8'd6, 32'd5, 32'd6, 1'b0, '0));
      send_request(make_report(CMD_PROBE, 8'd1, 32'd6002, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_SAMPLE, 8'd1, 32'hFFFF_FF00, 8'd7, '1, '0, 1'b1, '0));
      send_request(make_report(CMD_IDENT, 8'd8, 32'd0, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_PROBE, 8'd8, 32'd0, 8'd0, '0, '0, 1'b0, '0));
      // Age across the 32-bit time wrap.
      send_request(make_report(CMD_PROBE, 8'd1, 32'h100, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_SAMPLE, 8'd8, 32'd0, 8'hFF, NAN_BITS, 32'h0080_0000,
                               1'b1, '0));
      send_request(make_report(CMD_PROBE, 8'd8, 32'd0, 8'd0, '0, '0, 1'b0, '0));
      send_request(make_report(CMD_IDENT, 8'd8, 32'd5, 8'd0, '0, '0, 1'b0,
                               64'h0123_4567_89AB_CDEF));
      send_request(make_report(CMD_PROBE, 8'd8, '1, 8'd0, '0, '0, 1'b0, '0));
      // Freshness is reported even when the identity is missing.
      send_request(make_report(CMD_SAMPLE, 8'd2, 32'd0, 8'd0, 32'h4120_0000, 32'h4248_0000,
                               1'b1, '0));
      send_request(make_report(CMD_PROBE, 8'd2, 32'd10, 8'd0, '0, '0, 1'b0, '0));
   endtask

   // Main stimulus.
   initial begin
      int ph;
      int n;
      logic [TIME_W-1:0] stale_val;
      logic [TIME_W-1:0] air_val;
      req_chan.valid            = 1'b0;
      req_chan.cmd              = CMD_SAMPLE;
      req_chan.node_id          = '0;
      req_chan.now_ms           = '0;
      req_chan.seq_num          = '0;
      req_chan.temp_bits        = '0;
      req_chan.humidity_bits    = '0;
      req_chan.sensor_good      = 1'b0;
      req_chan.remote_sensor_id = '0;
      rsp_chan.ready            = 1'b0;
      csr_psel                  = 1'b0;
      csr_penable               = 1'b0;
      csr_pwrite                = 1'b0;
      csr_paddr                 = '0;
      csr_pwdata                = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results();
         stale_val = ph_stale[ph];
         air_val   = ph_air[ph];
         if (ph == PRESSURE_PH) begin
            stale_val = $urandom_range(2000, 20);
            air_val   = $urandom_range(2000, 20);
         end
         csr_write(REG_NODE_COUNT, {{(CSR_DATA_W-COUNT_W){1'b0}}, ph_count[ph]});
         csr_write(REG_STALE_MS, stale_val);
         csr_write(REG_AIR_MS, air_val);
         send_idle_pct = ph_send[ph];
         stall_pct     = ph_stall[ph];
         for (n = 0; n < ph_items[ph]; n++) begin
            // Long receiver hold while requests keep coming, later a full pause.
            if (ph == PRESSURE_PH && n == 20) hold_request = 1'b1;
            if (ph == PRESSURE_PH && n == 55) drain_results();
            send_request(random_request());
         end
      end

      drain_results();
      $display("Covered %0d request words, %0d probes and %0d stale refusals.",
               node_board.requests, node_board.probes, node_board.refusals);
      $display("Used %0d register writes over %0d phases with varied channel stalls.",
               node_board.settings, NUM_PHASES);
      if (node_board.errors == 0 && node_board.pending_status_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/sns_pkg.sv
rtl/sns_if.sv
rtl/sns_ram.sv
rtl/sns_csr.sv
rtl/sensor_node_status_table.sv
dv/tb.sv
